// File: design/tac_pkg.sv
// Shared types, register map and reset values of the tamper alarm controller.
`default_nettype none

package tac_pkg;

  // Elapsed-time counter width default.
  localparam int TIMER_BITS_DEF = 16;

  // Register widths.
  localparam int TRIG_W   = 5;
  localparam int CFG_TIME_W = 16;
  localparam int SHORT_W  = 10;

  // Configuration bus.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;

  // Register reset values.
  localparam logic [TRIG_W-1:0]     TRIGGER_RST      = 5'd12;
  localparam logic [CFG_TIME_W-1:0] WINDOW_RST       = 16'd2000;
  localparam logic [CFG_TIME_W-1:0] ALARM_HOLD_RST   = 16'd5000;
  localparam logic [CFG_TIME_W-1:0] ALERT_HOLDOFF_RST = 16'd10000;
  localparam logic [CFG_TIME_W-1:0] UNAUTH_HOLDOFF_RST = 16'd10000;
  localparam logic [SHORT_W-1:0]    DOOR_CONFIRM_RST = 10'd80;
  localparam logic [SHORT_W-1:0]    VIB_DEAD_RST     = 10'd20;

  // Register index, taken from paddr word address.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TRIGGER        = 3'd0,
    REG_WINDOW         = 3'd1,
    REG_ALARM_HOLD     = 3'd2,
    REG_ALERT_HOLDOFF  = 3'd3,
    REG_UNAUTH_HOLDOFF = 3'd4,
    REG_DOOR_CONFIRM   = 3'd5,
    REG_VIB_DEAD       = 3'd6
  } cfg_idx_t;

  // Door event codes.
  typedef enum logic [1:0] {
    EVT_NONE   = 2'd0,
    EVT_UNLOCK = 2'd1,
    EVT_UNAUTH = 2'd2,
    EVT_LOCKED = 2'd3
  } door_evt_t;

  // Safe state codes.
  typedef enum logic [1:0] {
    MODE_LOCKED = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_ALARM  = 2'd2
  } mode_t;

endpackage

`default_nettype wire

// File: design/tamper_alarm_controller_top.sv
// Tamper alarm controller: vibration alert, door confirmation and safe state tracking.
`default_nettype none

// Channel   Direction  Handshake           Payload
// in_       input      in_valid/in_stall   vibration_level, door_level, auth_ok, flame_active
// out_      output     out_valid/out_stall vibration_alert, door_event, clear_auth,
//                                          alarm_active, door_open, tracking_request,
//                                          guard_state
// cfg       input      APB psel/penable    seven control registers, word addressed
//
// One tick transfer is accepted every clock cycle while in_stall is low; each tick
// passes from the input register through the tick update to the result register.
// All counters and flags of a tick are updated together in that single tick update.
// Synchronous reset clears all tick state and loads the register defaults.
// When the result register is stalled, the input register holds one more tick and the
// input side stalls only once both are full.

module tamper_alarm_controller_top #(
  parameter int TIMER_BITS = tac_pkg::TIMER_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // Tick input channel
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic                         in_vibration_level,
  input  wire logic                         in_door_level,
  input  wire logic                         in_auth_ok,
  input  wire logic                         in_flame_active,
  // Result channel
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic                              out_vibration_alert,
  output logic [1:0]                        out_door_event,
  output logic                              out_clear_auth,
  output logic                              out_alarm_active,
  output logic                              out_door_open,
  output logic                              out_tracking_request,
  output logic [1:0]                        out_guard_state,
  // Configuration port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [tac_pkg::CFG_ADDR_W-1:0] paddr,
  input  wire logic [tac_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [tac_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);

  import tac_pkg::*;

  // Comparisons between elapsed counters and 16-bit limits run at the wider width.
  localparam int CmpW = (TIMER_BITS > CFG_TIME_W) ? TIMER_BITS : CFG_TIME_W;

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [TRIG_W-1:0]     trigger_r;
  logic [CFG_TIME_W-1:0] window_r;
  logic [CFG_TIME_W-1:0] alarm_hold_r;
  logic [CFG_TIME_W-1:0] alert_holdoff_r;
  logic [CFG_TIME_W-1:0] unauth_holdoff_r;
  logic [SHORT_W-1:0]    door_confirm_r;
  logic [SHORT_W-1:0]    vib_dead_r;

  logic     cfg_wr;
  cfg_idx_t cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = cfg_idx_t'(paddr[CFG_IDX_W+1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trigger_r        <= TRIGGER_RST;
      window_r         <= WINDOW_RST;
      alarm_hold_r     <= ALARM_HOLD_RST;
      alert_holdoff_r  <= ALERT_HOLDOFF_RST;
      unauth_holdoff_r <= UNAUTH_HOLDOFF_RST;
      door_confirm_r   <= DOOR_CONFIRM_RST;
      vib_dead_r       <= VIB_DEAD_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TRIGGER:        trigger_r        <= pwdata[TRIG_W-1:0];
        REG_WINDOW:         window_r         <= pwdata[CFG_TIME_W-1:0];
        REG_ALARM_HOLD:     alarm_hold_r     <= pwdata[CFG_TIME_W-1:0];
        REG_ALERT_HOLDOFF:  alert_holdoff_r  <= pwdata[CFG_TIME_W-1:0];
        REG_UNAUTH_HOLDOFF: unauth_holdoff_r <= pwdata[CFG_TIME_W-1:0];
        REG_DOOR_CONFIRM:   door_confirm_r   <= pwdata[SHORT_W-1:0];
        REG_VIB_DEAD:       vib_dead_r       <= pwdata[SHORT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TRIGGER:        prdata = CFG_DATA_W'(trigger_r);
      REG_WINDOW:         prdata = CFG_DATA_W'(window_r);
      REG_ALARM_HOLD:     prdata = CFG_DATA_W'(alarm_hold_r);
      REG_ALERT_HOLDOFF:  prdata = CFG_DATA_W'(alert_holdoff_r);
      REG_UNAUTH_HOLDOFF: prdata = CFG_DATA_W'(unauth_holdoff_r);
      REG_DOOR_CONFIRM:   prdata = CFG_DATA_W'(door_confirm_r);
      REG_VIB_DEAD:       prdata = CFG_DATA_W'(vib_dead_r);
      default:            prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Input register and transfer control
  // ---------------------------------------------------------------------------
  logic in_vld_r;
  logic vib_in_r, door_in_r, auth_in_r, flame_in_r;
  logic out_vld_r;
  logic advance;

  // A tick is processed when the input register is full and the result register
  // is empty or being emptied in this cycle.
  assign advance  = in_vld_r & (~out_vld_r | ~out_stall);
  assign in_stall = in_vld_r & ~advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      vib_in_r   <= in_vibration_level;
      door_in_r  <= in_door_level;
      auth_in_r  <= in_auth_ok;
      flame_in_r <= in_flame_active;
    end
  end

  // ---------------------------------------------------------------------------
  // Tick state
  // ---------------------------------------------------------------------------
  logic                  last_vib_r, last_vib_nxt;
  logic [TRIG_W-1:0]     edge_cnt_r, edge_cnt_nxt;
  logic [TIMER_BITS-1:0] since_first_r, since_first_nxt;
  logic [SHORT_W-1:0]    dead_r, dead_nxt;
  logic [TIMER_BITS-1:0] since_alert_r, since_alert_nxt;
  logic                  vib_active_r, vib_active_nxt;
  logic [TIMER_BITS-1:0] since_alarm_r, since_alarm_nxt;
  logic                  last_door_r, last_door_nxt;
  logic                  pending_r, pending_nxt;
  logic [SHORT_W-1:0]    confirm_r, confirm_nxt;
  logic [TIMER_BITS-1:0] since_unauth_r, since_unauth_nxt;
  logic                  unauth_sent_r, unauth_sent_nxt;
  logic                  lock_sent_r, lock_sent_nxt;
  mode_t                 mode_r, mode_nxt;
  logic                  alarm_r, alarm_nxt;
  logic                  door_flag_r, door_flag_nxt;
  logic                  tracking_r, tracking_nxt;

  logic                  alert_nxt;
  door_evt_t             event_nxt;
  logic                  clr_nxt;
  logic                  check_door;

  // Saturating increment of an elapsed counter.
  function automatic logic [TIMER_BITS-1:0] tick_up(input logic [TIMER_BITS-1:0] v);
    tick_up = (&v) ? v : v + 1'b1;
  endfunction

  always_comb begin
    last_vib_nxt     = last_vib_r;
    edge_cnt_nxt     = edge_cnt_r;
    dead_nxt         = dead_r;
    vib_active_nxt   = vib_active_r;
    last_door_nxt    = last_door_r;
    pending_nxt      = pending_r;
    confirm_nxt      = confirm_r;
    unauth_sent_nxt  = unauth_sent_r;
    lock_sent_nxt    = lock_sent_r;
    mode_nxt         = mode_r;
    alarm_nxt        = alarm_r;
    door_flag_nxt    = door_flag_r;
    tracking_nxt     = tracking_r;
    alert_nxt        = 1'b0;
    event_nxt        = EVT_NONE;
    clr_nxt          = 1'b0;
    check_door       = 1'b0;

    since_first_nxt  = tick_up(since_first_r);
    since_alert_nxt  = tick_up(since_alert_r);
    since_alarm_nxt  = tick_up(since_alarm_r);
    since_unauth_nxt = tick_up(since_unauth_r);

    // Falling vibration edge, sampled only outside the dead time.
    if (dead_r != '0) begin
      dead_nxt = dead_r - 1'b1;
    end else begin
      if (last_vib_r && !vib_in_r) begin
        if (edge_cnt_r == '0) begin
          since_first_nxt = '0;
        end
        if (!(&edge_cnt_r)) begin
          edge_cnt_nxt = edge_cnt_r + 1'b1;
        end
        dead_nxt = vib_dead_r;
      end
      last_vib_nxt = vib_in_r;
    end

    // Alert when enough edges fell inside the window and the alert holdoff has passed.
    if (edge_cnt_nxt >= trigger_r &&
        CmpW'(since_first_nxt) < CmpW'(window_r)) begin
      if (CmpW'(since_alert_nxt) > CmpW'(alert_holdoff_r)) begin
        alert_nxt       = 1'b1;
        vib_active_nxt  = 1'b1;
        since_alarm_nxt = '0;
        since_alert_nxt = '0;
        mode_nxt        = MODE_ALARM;
        alarm_nxt       = 1'b1;
        tracking_nxt    = 1'b1;
      end
      edge_cnt_nxt = '0;
    end

    if (CmpW'(since_first_nxt) > CmpW'(window_r)) begin
      edge_cnt_nxt = '0;
    end

    // Auto-clear after the hold time unless the door is open or a flame is seen.
    if (vib_active_nxt && CmpW'(since_alarm_nxt) > CmpW'(alarm_hold_r) &&
        !door_flag_r && !flame_in_r) begin
      vib_active_nxt = 1'b0;
      alarm_nxt      = 1'b0;
      if (mode_nxt == MODE_ALARM) begin
        mode_nxt = MODE_LOCKED;
      end
    end

    // Door change confirmation.
    if (pending_r) begin
      if (confirm_r != '0) begin
        confirm_nxt = confirm_r - 1'b1;
      end
      if (confirm_nxt == '0) begin
        pending_nxt = 1'b0;
        check_door  = 1'b1;
      end
    end else if (door_in_r != last_door_r) begin
      if (door_confirm_r == '0) begin
        check_door = 1'b1;
      end else begin
        pending_nxt = 1'b1;
        confirm_nxt = door_confirm_r;
      end
    end

    if (check_door && door_in_r != last_door_r) begin
      if (door_in_r) begin
        door_flag_nxt = 1'b1;
        lock_sent_nxt = 1'b0;
        if (auth_in_r) begin
          mode_nxt  = MODE_OPEN;
          event_nxt = EVT_UNLOCK;
        end else if (!unauth_sent_r &&
                     CmpW'(since_unauth_nxt) > CmpW'(unauth_holdoff_r)) begin
          unauth_sent_nxt  = 1'b1;
          since_unauth_nxt = '0;
          mode_nxt         = MODE_ALARM;
          event_nxt        = EVT_UNAUTH;
          alarm_nxt        = 1'b1;
          tracking_nxt     = 1'b1;
        end
      end else begin
        door_flag_nxt   = 1'b0;
        clr_nxt         = 1'b1;
        alarm_nxt       = 1'b0;
        unauth_sent_nxt = 1'b0;
        vib_active_nxt  = 1'b0;
        if (!lock_sent_r) begin
          lock_sent_nxt = 1'b1;
          mode_nxt      = MODE_LOCKED;
          event_nxt     = EVT_LOCKED;
        end
      end
      last_door_nxt = door_in_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_vib_r     <= 1'b1;
      edge_cnt_r     <= '0;
      since_first_r  <= '0;
      dead_r         <= '0;
      since_alert_r  <= '0;
      vib_active_r   <= 1'b0;
      since_alarm_r  <= '0;
      last_door_r    <= 1'b0;
      pending_r      <= 1'b0;
      confirm_r      <= '0;
      since_unauth_r <= '0;
      unauth_sent_r  <= 1'b0;
      lock_sent_r    <= 1'b0;
      mode_r         <= MODE_LOCKED;
      alarm_r        <= 1'b0;
      door_flag_r    <= 1'b0;
      tracking_r     <= 1'b0;
    end else if (advance) begin
      last_vib_r     <= last_vib_nxt;
      edge_cnt_r     <= edge_cnt_nxt;
      since_first_r  <= since_first_nxt;
      dead_r         <= dead_nxt;
      since_alert_r  <= since_alert_nxt;
      vib_active_r   <= vib_active_nxt;
      since_alarm_r  <= since_alarm_nxt;
      last_door_r    <= last_door_nxt;
      pending_r      <= pending_nxt;
      confirm_r      <= confirm_nxt;
      since_unauth_r <= since_unauth_nxt;
      unauth_sent_r  <= unauth_sent_nxt;
      lock_sent_r    <= lock_sent_nxt;
      mode_r         <= mode_nxt;
      alarm_r        <= alarm_nxt;
      door_flag_r    <= door_flag_nxt;
      tracking_r     <= tracking_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic       alert_out_r;
  logic [1:0] event_out_r;
  logic       clr_out_r;
  logic       alarm_out_r;
  logic       door_out_r;
  logic       tracking_out_r;
  logic [1:0] mode_out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      alert_out_r    <= alert_nxt;
      event_out_r    <= event_nxt;
      clr_out_r      <= clr_nxt;
      alarm_out_r    <= alarm_nxt;
      door_out_r     <= door_flag_nxt;
      tracking_out_r <= tracking_nxt;
      mode_out_r     <= mode_nxt;
    end
  end

  assign out_valid            = out_vld_r;
  assign out_vibration_alert  = alert_out_r;
  assign out_door_event       = event_out_r;
  assign out_clear_auth       = clr_out_r;
  assign out_alarm_active     = alarm_out_r;
  assign out_door_open        = door_out_r;
  assign out_tracking_request = tracking_out_r;
  assign out_guard_state      = mode_out_r;

endmodule

`default_nettype wire
